[src/pgmh_pkg.sv]
// ============================================================================
// pgmh_pkg: shared types and constants of the PGM pixel histogram core
// Holds the transaction structs, the command codes, the parser phases and
// the sizing constants that the parser, the bin store and the top level use.
// ============================================================================
package pgmh_pkg;

    // Histogram geometry.
    localparam int NUM_BINS     = 256;
    localparam int BIN_IDX_BITS = 8;

    // Width of the bin count field in a result transaction.
    localparam int BIN_COUNT_W = 24;

    // Default storage width of one bin counter.
    localparam int COUNT_BITS_DEF = 24;

    // Number of maxval bytes skipped after the height.
    localparam int MAXVAL_SKIP = 4;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int DIM_W   = 16;
    localparam int PHASE_W = 3;
    localparam int BCNT_W  = 3;
    localparam int PIX_W   = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;

    // Parser phases.
    typedef enum logic [PHASE_W-1:0] {
        PH_MAGIC  = 3'd0,
        PH_SEP    = 3'd1,
        PH_WIDTH  = 3'd2,
        PH_HEIGHT = 3'd3,
        PH_MAXVAL = 3'd4,
        PH_PIXELS = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    // One input transaction.
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [BYTE_W-1:0]       byte_in;
        logic [BIN_IDX_BITS-1:0] bin_index;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [BIN_COUNT_W-1:0] bin_count;
        logic [DIM_W-1:0]       image_width;
        logic [DIM_W-1:0]       image_height;
        logic [PHASE_W-1:0]     phase;
        logic                   format_error;
    } t_out_item;

    // Parser state as seen after one transaction.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        t_phase           phase;
        logic             format_error;
    } t_parse_status;

    // Request from the parser to the bin store.
    typedef struct packed {
        logic                    clear;
        logic                    inc;
        logic                    rd;
        logic [BIN_IDX_BITS-1:0] addr;
    } t_bin_req;

    // Pipeline control from the top level.
    typedef struct packed {
        logic accept;
        logic advance;
    } t_pipe_ctrl;

endpackage

[src/pgmh_parser.sv]
// ============================================================================
// pgmh_parser: PGM header parser
// Walks the magic, separator, width, height and maxval fields of a P5 file,
// then counts down the pixel bytes and issues one bin request per
// transaction.
// ============================================================================
module pgmh_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  pgmh_pkg::t_in_item     i_item,
    output pgmh_pkg::t_parse_status o_status,
    output pgmh_pkg::t_bin_req     o_req
);

    localparam logic [pgmh_pkg::BYTE_W-1:0] MAGIC_P    = 8'h50;
    localparam logic [pgmh_pkg::BYTE_W-1:0] MAGIC_5    = 8'h35;
    localparam logic [pgmh_pkg::BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [pgmh_pkg::BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [pgmh_pkg::BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [pgmh_pkg::BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [pgmh_pkg::DIM_W-1:0]  DIM_MAX    = '1;
    localparam logic [pgmh_pkg::BCNT_W-1:0] SKIP_LAST  =
        pgmh_pkg::BCNT_W'(pgmh_pkg::MAXVAL_SKIP);

    // Append one decimal digit; non-digits count as zero, result saturates.
    function automatic logic [pgmh_pkg::DIM_W-1:0] add_digit(
        input logic [pgmh_pkg::DIM_W-1:0]  acc,
        input logic [pgmh_pkg::BYTE_W-1:0] b
    );
        logic [3:0]                   d;
        logic [pgmh_pkg::DIM_W+3:0]   v;
        d = (b >= CH_ZERO && b <= CH_NINE) ? 4'(b - CH_ZERO) : 4'd0;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{pgmh_pkg::DIM_W{1'b0}}, d};
        add_digit = (v > {4'b0000, DIM_MAX}) ? DIM_MAX : v[pgmh_pkg::DIM_W-1:0];
    endfunction

    pgmh_pkg::t_phase                r_phase, n_phase;
    logic [pgmh_pkg::BCNT_W-1:0]     r_bcnt, n_bcnt;
    logic [pgmh_pkg::DIM_W-1:0]      r_width, n_width;
    logic [pgmh_pkg::DIM_W-1:0]      r_height, n_height;
    logic [pgmh_pkg::PIX_W-1:0]      r_pix_left, n_pix_left;
    logic                            r_err, n_err;
    logic [pgmh_pkg::BCNT_W-1:0]     bcnt_inc;
    logic [pgmh_pkg::PIX_W-1:0]      pix_total;
    logic                            pixel_byte;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pgmh_pkg::PH_MAGIC;
            r_bcnt     <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_pix_left <= '0;
            r_err      <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_bcnt     <= n_bcnt;
            r_width    <= n_width;
            r_height   <= n_height;
            r_pix_left <= n_pix_left;
            r_err      <= n_err;
        end
    end

    assign bcnt_inc  = r_bcnt + {{(pgmh_pkg::BCNT_W-1){1'b0}}, 1'b1};
    assign pix_total = {{pgmh_pkg::DIM_W{1'b0}}, r_width} *
                       {{pgmh_pkg::DIM_W{1'b0}}, r_height};

    // Next-state logic for one transaction.
    always_comb begin
        n_phase    = r_phase;
        n_bcnt     = r_bcnt;
        n_width    = r_width;
        n_height   = r_height;
        n_pix_left = r_pix_left;
        n_err      = r_err;
        pixel_byte = 1'b0;
        unique case (i_item.cmd)
            pgmh_pkg::CMD_START: begin
                n_phase    = pgmh_pkg::PH_MAGIC;
                n_bcnt     = '0;
                n_width    = '0;
                n_height   = '0;
                n_pix_left = '0;
                n_err      = 1'b0;
            end
            pgmh_pkg::CMD_BYTE: begin
                if (!r_err) begin
                    unique case (r_phase)
                        pgmh_pkg::PH_MAGIC: begin
                            if (i_item.byte_in != ((r_bcnt == '0) ? MAGIC_P : MAGIC_5)) begin
                                n_err = 1'b1;
                            end else if (r_bcnt == '0) begin
                                n_bcnt = 3'd1;
                            end else begin
                                n_bcnt  = '0;
                                n_phase = pgmh_pkg::PH_SEP;
                            end
                        end
                        pgmh_pkg::PH_SEP: begin
                            n_phase = pgmh_pkg::PH_WIDTH;
                        end
                        pgmh_pkg::PH_WIDTH: begin
                            if (i_item.byte_in == CH_SPACE) begin
                                n_phase = pgmh_pkg::PH_HEIGHT;
                            end else begin
                                n_width = add_digit(r_width, i_item.byte_in);
                            end
                        end
                        pgmh_pkg::PH_HEIGHT: begin
                            if (i_item.byte_in == CH_NEWLINE) begin
                                n_phase = pgmh_pkg::PH_MAXVAL;
                                n_bcnt  = '0;
                            end else begin
                                n_height = add_digit(r_height, i_item.byte_in);
                            end
                        end
                        pgmh_pkg::PH_MAXVAL: begin
                            if (bcnt_inc >= SKIP_LAST) begin
                                n_bcnt     = '0;
                                n_pix_left = pix_total;
                                n_phase    = (pix_total != '0) ? pgmh_pkg::PH_PIXELS
                                                               : pgmh_pkg::PH_DONE;
                            end else begin
                                n_bcnt = bcnt_inc;
                            end
                        end
                        pgmh_pkg::PH_PIXELS: begin
                            pixel_byte = 1'b1;
                            n_pix_left = r_pix_left - {{(pgmh_pkg::PIX_W-1){1'b0}}, 1'b1};
                            if (r_pix_left == {{(pgmh_pkg::PIX_W-1){1'b0}}, 1'b1}) begin
                                n_phase = pgmh_pkg::PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Status after the transaction and the request to the bin store.
    assign o_status.width        = n_width;
    assign o_status.height       = n_height;
    assign o_status.phase        = n_phase;
    assign o_status.format_error = n_err;

    assign o_req.clear = (i_item.cmd == pgmh_pkg::CMD_START);
    assign o_req.inc   = pixel_byte;
    assign o_req.rd    = (i_item.cmd == pgmh_pkg::CMD_READ);
    assign o_req.addr  = (i_item.cmd == pgmh_pkg::CMD_READ) ? i_item.bin_index
                                                            : i_item.byte_in;

endmodule

[src/pgmh_bin_store.sv]
// ============================================================================
// pgmh_bin_store: histogram bin memory
// A 256-entry counter memory with one registered read port and one write
// port. Increments are pipelined read-modify-write with forwarding of the
// value written in the same cycle. Valid bits give cleared bins at once.
// ============================================================================
module pgmh_bin_store #(
    parameter int COUNT_BITS = pgmh_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pgmh_pkg::t_pipe_ctrl                i_ctrl,
    input  pgmh_pkg::t_bin_req                  i_req,
    output logic [pgmh_pkg::BIN_COUNT_W-1:0]    o_bin_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0]             r_mem [pgmh_pkg::NUM_BINS];
    logic [COUNT_BITS-1:0]             r_rd_data;
    logic [pgmh_pkg::NUM_BINS-1:0]     r_valid;

    logic                              r_s1_inc;
    logic                              r_s1_rd;
    logic [pgmh_pkg::BIN_IDX_BITS-1:0] r_s1_addr;
    logic                              r_s1_fwd;
    logic [COUNT_BITS-1:0]             r_s1_fwd_val;
    logic                              r_s1_vbit;

    logic [COUNT_BITS-1:0]             cur_val;
    logic [COUNT_BITS-1:0]             new_val;
    logic                              wr_en;
    logic [31:0]                       cur_ext;

    // Current bin value in stage 1: forwarded, stored or cleared.
    assign cur_val = r_s1_fwd  ? r_s1_fwd_val :
                     r_s1_vbit ? r_rd_data    : '0;
    assign new_val = (cur_val == COUNT_MAX) ? cur_val
                                            : cur_val + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign wr_en   = i_ctrl.advance && r_s1_inc;

    // Stage 1 request register, captured with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_s1_inc     <= i_req.inc;
            r_s1_rd      <= i_req.rd;
            r_s1_addr    <= i_req.addr;
            r_s1_fwd     <= wr_en && (r_s1_addr == i_req.addr);
            r_s1_fwd_val <= new_val;
            r_s1_vbit    <= r_valid[i_req.addr];
        end
    end

    // Counter memory: write from stage 1, registered read at accept.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= new_val;
        end
        if (i_ctrl.accept) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // Valid bits: a start command clears every bin at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.accept && i_req.clear) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_s1_addr] <= 1'b1;
        end
    end

    // Read result, low bits of the bin; zero for other commands.
    assign cur_ext     = 32'(cur_val);
    assign o_bin_count = r_s1_rd ? cur_ext[pgmh_pkg::BIN_COUNT_W-1:0] : '0;

endmodule

[src/pgm_pixel_histogram_core.sv]
// ============================================================================
// pgm_pixel_histogram_core: streaming histogram of a binary PGM image
// Parses the P5 header byte by byte and counts pixel bytes into 256 bins;
// supports bin reads and a start command that clears parser and bins.
// ============================================================================
// Path: an accepted transaction is held in the stage 1 registers, then its
// result moves into the output register.
// Throughput: one transaction per cycle unless the output stalls; the
// bin read-modify-write is pipelined, forwarding the write to the next read.
// Reset: clears the parser and the 256 bin valid bits at once; no clearing
// pass, the block accepts input as soon as reset is released.
module pgm_pixel_histogram_core #(
    parameter int COUNT_BITS = pgmh_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pgmh_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pgmh_pkg::t_out_item o_out_item
);

    pgmh_pkg::t_pipe_ctrl    ctrl;
    pgmh_pkg::t_parse_status status;
    pgmh_pkg::t_bin_req      req;
    logic [pgmh_pkg::BIN_COUNT_W-1:0] bin_count;

    logic                    r_s1_valid;
    pgmh_pkg::t_parse_status r_s1_status;
    logic                    r_out_valid;
    pgmh_pkg::t_out_item     r_out_item;
    logic                    out_free;

    // Handshake: stage 1 moves on when the output register is free or drains.
    assign out_free     = !r_out_valid || !i_out_stall;
    assign ctrl.advance = r_s1_valid && out_free;
    assign o_in_stall   = r_s1_valid && !out_free;
    assign ctrl.accept  = i_in_valid && !o_in_stall;

    pgmh_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (ctrl.accept),
        .i_item   (i_in_item),
        .o_status (status),
        .o_req    (req)
    );

    pgmh_bin_store #(
        .COUNT_BITS (COUNT_BITS)
    ) u_bin_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_req       (req),
        .o_bin_count (bin_count)
    );

    // Stage 1 valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ctrl.accept) begin
            r_s1_valid <= 1'b1;
        end else if (ctrl.advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 parser status.
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_s1_status <= status;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (ctrl.advance) begin
            r_out_item.bin_count    <= bin_count;
            r_out_item.image_width  <= r_s1_status.width;
            r_out_item.image_height <= r_s1_status.height;
            r_out_item.phase        <= r_s1_status.phase;
            r_out_item.format_error <= r_s1_status.format_error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[test/pgm_pixel_histogram_core_tb.sv]
// ============================================================================
// pgm_pixel_histogram_core_tb: self-checking testbench of the PGM histogram
// Feeds P5 files, bin reads and start commands through the valid/stall input
// channel, predicts every result with a behavioral histogram model, and
// compares each result transaction field by field as it leaves the block.
// ============================================================================
module pgm_pixel_histogram_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code that the block must leave without effect.
    localparam logic [pgmh_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Characters that steer the header parser.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] BIN_MAX     = (32'd1 << pgmh_pkg::COUNT_BITS_DEF) - 32'd1;
    localparam int          ITEM_TARGET = 1050;
    localparam int          PIXEL_CAP   = 200;

    logic                i_clk    = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    pgmh_pkg::t_in_item  in_item  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pgmh_pkg::t_out_item out_item;

    // While set, neither side idles.
    bit quiet = 1'b0;

    int mismatches = 0;
    int items_done = 0;

    // Results predicted for accepted transactions, oldest first.
    pgmh_pkg::t_out_item histo_results_q[$];

    // Shadow copy of the parser state and of the bin store.
    pgmh_pkg::t_phase sh_phase;
    logic [2:0]       sh_pos;
    logic [15:0]      sh_width;
    logic [15:0]      sh_height;
    logic [31:0]      sh_pix_left;
    logic             sh_error;
    logic [31:0]      sh_bins [pgmh_pkg::NUM_BINS];

    pgm_pixel_histogram_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Clear the shadow parser and every shadow bin.
    function automatic void clear_shadow();
        sh_phase    = pgmh_pkg::PH_MAGIC;
        sh_pos      = '0;
        sh_width    = '0;
        sh_height   = '0;
        sh_pix_left = '0;
        sh_error    = 1'b0;
        for (int i = 0; i < pgmh_pkg::NUM_BINS; i++) begin
            sh_bins[i] = '0;
        end
    endfunction

    // Append one decimal digit to a dimension; non-digits count as zero.
    function automatic logic [15:0] append_digit(logic [15:0] acc, logic [7:0] b);
        logic [31:0] d;
        logic [31:0] v;
        d = (b >= CH_ZERO && b <= CH_NINE) ? 32'(b - CH_ZERO) : 32'd0;
        v = 32'(acc) * 32'd10 + d;
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // Apply one transaction to the shadow state and form its result.
    function automatic pgmh_pkg::t_out_item histogram_step(pgmh_pkg::t_in_item it,
                                                           output bit useful);
        pgmh_pkg::t_out_item res;
        logic [7:0]          b;
        logic [31:0]         count;
        b      = it.byte_in;
        count  = '0;
        useful = 1'b1;
        if (it.cmd == pgmh_pkg::CMD_BYTE) begin
            useful = !sh_error && sh_phase != pgmh_pkg::PH_DONE;
            if (!sh_error) begin
                case (sh_phase)
                    pgmh_pkg::PH_MAGIC: begin
                        if (b != ((sh_pos == 3'd0) ? CH_P : CH_5)) begin
                            sh_error = 1'b1;
                        end else if (sh_pos == 3'd0) begin
                            sh_pos = 3'd1;
                        end else begin
                            sh_pos   = 3'd0;
                            sh_phase = pgmh_pkg::PH_SEP;
                        end
                    end
                    pgmh_pkg::PH_SEP: begin
                        sh_phase = pgmh_pkg::PH_WIDTH;
                    end
                    pgmh_pkg::PH_WIDTH: begin
                        if (b == CH_SPACE) sh_phase = pgmh_pkg::PH_HEIGHT;
                        else sh_width = append_digit(sh_width, b);
                    end
                    pgmh_pkg::PH_HEIGHT: begin
                        if (b == CH_NL) begin
                            sh_phase = pgmh_pkg::PH_MAXVAL;
                            sh_pos   = 3'd0;
                        end else begin
                            sh_height = append_digit(sh_height, b);
                        end
                    end
                    pgmh_pkg::PH_MAXVAL: begin
                        sh_pos = sh_pos + 3'd1;
                        if (sh_pos >= 3'(pgmh_pkg::MAXVAL_SKIP)) begin
                            sh_pos      = 3'd0;
                            sh_pix_left = 32'(sh_width) * 32'(sh_height);
                            sh_phase    = (sh_pix_left != 0) ? pgmh_pkg::PH_PIXELS
                                                             : pgmh_pkg::PH_DONE;
                        end
                    end
                    pgmh_pkg::PH_PIXELS: begin
                        if (sh_bins[b] < BIN_MAX) sh_bins[b] = sh_bins[b] + 32'd1;
                        sh_pix_left = sh_pix_left - 32'd1;
                        if (sh_pix_left == 0) sh_phase = pgmh_pkg::PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (it.cmd == pgmh_pkg::CMD_READ) begin
            count = sh_bins[it.bin_index];
        end else if (it.cmd == pgmh_pkg::CMD_START) begin
            clear_shadow();
        end
        res.bin_count    = count[pgmh_pkg::BIN_COUNT_W-1:0];
        res.image_width  = sh_width;
        res.image_height = sh_height;
        res.phase        = sh_phase;
        res.format_error = sh_error;
        return res;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        mismatches++;
    endtask

    // Send one transaction; called and left at a rising clock edge.
    task automatic send_item(logic [pgmh_pkg::CMD_W-1:0] cmd, logic [7:0] b,
                             logic [7:0] idx);
        pgmh_pkg::t_in_item  it;
        pgmh_pkg::t_out_item res;
        bit                  useful;
        bit                  taken;
        it.cmd       = cmd;
        it.byte_in   = b;
        it.bin_index = idx;
        if (!quiet) begin
            while ($urandom_range(99) < 36) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        taken = 1'b0;
        useful = 1'b0;
        // Stall is settled at the falling edge; the transaction is taken at
        // the following rising edge when stall is low.
        while (!taken) begin
            @(negedge i_clk);
            taken = !in_stall;
            if (taken) begin
                res = histogram_step(it, useful);
                histo_results_q.push_back(res);
            end
            @(posedge i_clk);
        end
        if (useful) items_done++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(pgmh_pkg::CMD_BYTE, b, 8'($urandom_range(255)));
    endtask

    task automatic send_read(logic [7:0] idx);
        send_item(pgmh_pkg::CMD_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic send_start();
        send_item(pgmh_pkg::CMD_START, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // Send a decimal number and its terminator; when noisy, a stray random byte now and then.
    task automatic send_number(int value, logic [7:0] terminator, bit noisy);
        string      digits;
        logic [7:0] junk;
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++) begin
            if (noisy && $urandom_range(3) == 0) begin
                junk = 8'($urandom_range(255));
                if (junk == terminator) junk = junk + 8'd1;
                send_byte(junk);
            end
            send_byte(8'(digits[i]));
        end
        send_byte(terminator);
    endtask

    // Start a file and send a complete header.
    task automatic send_header(int w, int h, bit noisy);
        send_start();
        send_byte(CH_P);
        send_byte(CH_5);
        send_byte(8'($urandom_range(255)));
        send_number(w, CH_SPACE, noisy);
        send_number(h, CH_NL, noisy);
        for (int i = 0; i < pgmh_pkg::MAXVAL_SKIP; i++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // One well-formed file with random pixels, reads mixed in.
    task automatic send_random_file(bit noisy);
        int w;
        int h;
        int npix;
        w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        send_header(w, h, noisy);
        // Stray digits can inflate the size, so the pixel count comes from
        // the shadow parser and is capped.
        npix = (sh_phase == pgmh_pkg::PH_PIXELS) ? int'(sh_pix_left) : 0;
        if (npix > PIXEL_CAP) npix = PIXEL_CAP;
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(99) < 15) send_read(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(1) == 1) send_byte(8'($urandom_range(255)));
        for (int i = 0; i < 3; i++) begin
            send_read(8'($urandom_range(255)));
        end
    endtask

    // Wait with the input idle until every predicted result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (histo_results_q.size() != 0) @(posedge i_clk);
    endtask

    // Bad magic, bytes after the error, an unused command and a read.
    task automatic test_magic_errors();
        send_start();
        send_byte(CH_P);
        send_byte(8'h36);
        send_byte(CH_P);
        send_read(8'hFF);
        send_item(CMD_UNUSED, 8'hFF, 8'hFF);
        send_start();
        send_byte(8'h00);
    endtask

    // A two-pixel image with a non-digit in the width and extreme pixels.
    task automatic test_small_image();
        send_start();
        send_byte(CH_P);
        send_byte(CH_5);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(8'h32);
        send_byte(CH_SPACE);
        send_byte(8'h31);
        send_byte(CH_NL);
        for (int i = 0; i < pgmh_pkg::MAXVAL_SKIP; i++) send_byte(8'h39);
        send_byte(8'h00);
        send_byte(8'hFF);
        // Bytes after the image are ignored.
        send_byte(8'h80);
        send_read(8'h00);
        send_read(8'hFF);
        send_read(8'h80);
    endtask

    // Zero width with a saturating height goes straight to done.
    task automatic test_edge_dims();
        send_header(0, 999999, 1'b0);
        send_byte(8'h55);
        send_read(8'h55);
    endtask

    // Back-to-back files with neither side idling.
    task automatic test_steady_stream();
        int stop_at;
        stop_at = items_done + 150;
        quiet = 1'b1;
        while (items_done < stop_at) send_random_file(1'b0);
        quiet = 1'b0;
    endtask

    // The sender holds off until the block has returned every result.
    task automatic test_drain_pause();
        send_random_file(1'b0);
        drain_results();
        send_random_file(1'b1);
        send_read(8'($urandom_range(255)));
    endtask

    // Mostly well-formed files, some broken files and some raw noise.
    task automatic test_random_files();
        int kind;
        int n;
        while (items_done < ITEM_TARGET) begin
            kind = $urandom_range(99);
            if (kind < 72) begin
                send_random_file(kind < 15);
            end else if (kind < 82) begin
                // Broken magic: a wrong first or second byte.
                send_start();
                if ($urandom_range(1) == 1) send_byte(CH_P);
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
                send_read(8'($urandom_range(255)));
            end else if (kind < 90) begin
                // Truncated file: the next file starts in the middle of this one.
                send_header($urandom_range(4, 8), $urandom_range(4, 8), 1'b0);
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
                send_read(8'($urandom_range(255)));
            end else begin
                // Raw noise over every command code.
                for (int i = 0; i < 10; i++) begin
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                end
            end
        end
    endtask

    // Output stall, random except in steady stretches.
    always @(posedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 36);
    end

    // Compare every result that is taken at the next rising edge.
    always @(negedge i_clk) begin
        pgmh_pkg::t_out_item exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (histo_results_q.size() == 0) begin
                report_mismatch("result with nothing pending, bin_count", 0,
                                32'(out_item.bin_count));
            end else begin
                exp_r = histo_results_q.pop_front();
                if (out_item.bin_count !== exp_r.bin_count)
                    report_mismatch("bin_count", 32'(exp_r.bin_count),
                                    32'(out_item.bin_count));
                if (out_item.image_width !== exp_r.image_width)
                    report_mismatch("image_width", 32'(exp_r.image_width),
                                    32'(out_item.image_width));
                if (out_item.image_height !== exp_r.image_height)
                    report_mismatch("image_height", 32'(exp_r.image_height),
                                    32'(out_item.image_height));
                if (out_item.phase !== exp_r.phase)
                    report_mismatch("phase", 32'(exp_r.phase), 32'(out_item.phase));
                if (out_item.format_error !== exp_r.format_error)
                    report_mismatch("format_error", 32'(exp_r.format_error),
                                    32'(out_item.format_error));
            end
        end
    end

    // Test sequence.
    initial begin
        clear_shadow();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        test_magic_errors();
        test_small_image();
        test_edge_dims();
        test_steady_stream();
        test_drain_pause();
        test_random_files();
        drain_results();
        // Allow for the output latency before the final verdict.
        repeat (8) @(posedge i_clk);
        if (histo_results_q.size() != 0)
            report_mismatch("results never returned, count", 0,
                            32'(histo_results_q.size()));
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/pgmh_pkg.sv
src/pgmh_parser.sv
src/pgmh_bin_store.sv
src/pgm_pixel_histogram_core.sv
test/pgm_pixel_histogram_core_tb.sv
